// File: hw/rtl/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared widths, action codes and controller/datapath command types for the
// Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

   localparam int ACTION_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LENGTH_W = 6;
   localparam int BYTE_W   = 8;
   localparam int PAD_W    = 3;
   localparam int PEND_W   = 7;

   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int DEF_NUM_SYMBOLS  = 256;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

   typedef struct packed {
      logic wr_entry;
      logic rd_entry;
      logic merge;
      logic emit;
      logic flush;
   } hcbp_cmd_type;

   typedef struct packed {
      logic count_ge8;
   } hcbp_stat_type;

endpackage

// File: hw/rtl/hcbp_req_if.sv
// ----------------------------------------------------------------------------
// hcbp_req_if
// Request channel: codebook loads, symbols to encode and flushes.
// ----------------------------------------------------------------------------
interface hcbp_req_if;
   import hcbp_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SYMBOL_W-1:0] symbol;
   logic [CODE_W-1:0]   code_value;
   logic [LENGTH_W-1:0] code_length;

   modport source (output valid, output action, output symbol, output code_value,
                   output code_length, input ready);
   modport sink   (input valid, input action, input symbol, input code_value,
                   input code_length, output ready);
endinterface

// File: hw/rtl/hcbp_rsp_if.sv
// ----------------------------------------------------------------------------
// hcbp_rsp_if
// Response channel: packed bytes and end-of-chunk flush results.
// ----------------------------------------------------------------------------
interface hcbp_rsp_if;
   import hcbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_valid;
   logic [PAD_W-1:0]  padding_bits;
   logic              last;

   modport source (output valid, output out_byte, output byte_valid,
                   output padding_bits, output last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input padding_bits, input last, output ready);
endinterface

// File: hw/rtl/hcbp_ctrl.sv
// ----------------------------------------------------------------------------
// hcbp_ctrl
// Controller: request decode, sequencing of table read, merge and byte
// emission, and the response valid register.
// ----------------------------------------------------------------------------
module hcbp_ctrl #(
   parameter int NUM_SYMBOLS = hcbp_pkg::DEF_NUM_SYMBOLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [hcbp_pkg::ACTION_W-1:0] req_action,
   input  logic [hcbp_pkg::SYMBOL_W-1:0] req_symbol,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  hcbp_pkg::hcbp_stat_type       stat,
   output hcbp_pkg::hcbp_cmd_type        cmd
);
   import hcbp_pkg::*;

   localparam int STATE_W = 2;
   localparam logic [STATE_W-1:0] S_IDLE  = 2'd0;
   localparam logic [STATE_W-1:0] S_MERGE = 2'd1;
   localparam logic [STATE_W-1:0] S_EMIT  = 2'd2;
   localparam logic [STATE_W-1:0] S_FLUSH = 2'd3;

   logic [STATE_W-1:0] state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               sym_ok;
   logic               slot_free;

   assign sym_ok    = {1'b0, req_symbol} < (SYMBOL_W+1)'(NUM_SYMBOLS);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_action)
                  ACT_LOAD: begin
                     cmd.wr_entry = sym_ok;
                  end
                  ACT_ENCODE: begin
                     if (sym_ok) begin
                        cmd.rd_entry = 1'b1;
                        state_in     = S_MERGE;
                     end
                  end
                  ACT_FLUSH: begin
                     state_in = S_FLUSH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!stat.count_ge8) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               cmd.emit = 1'b1;
            end
         end
         S_FLUSH: begin
            if (slot_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit || cmd.flush) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_idle_no_full_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !stat.count_ge8)
      else $error("full byte left pending while idle");

   a_encode_to_merge: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_ENCODE && sym_ok)
      |=> (state_ff == S_MERGE))
      else $error("encode transfer did not start a merge");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.flush) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before transfer");

   a_load_no_wait: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action == ACT_LOAD) |=> (state_ff == S_IDLE))
      else $error("codebook load left idle");
`endif

endmodule

// File: hw/rtl/hcbp_dpath.sv
// ----------------------------------------------------------------------------
// hcbp_dpath
// Datapath: codebook memory, bit buffer with count, and response payload
// registers.
// ----------------------------------------------------------------------------
module hcbp_dpath #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hcbp_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic [hcbp_pkg::CODE_W-1:0]   req_code_value,
   input  logic [hcbp_pkg::LENGTH_W-1:0] req_code_length,
   input  hcbp_pkg::hcbp_cmd_type        cmd,
   output hcbp_pkg::hcbp_stat_type       stat,
   output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
   output logic                          byte_valid,
   output logic [hcbp_pkg::PAD_W-1:0]    padding_bits,
   output logic                          last
);
   import hcbp_pkg::*;

   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int LW      = $clog2(LEN_CAP + 1);
   localparam int ENT_W   = LW + LEN_CAP;
   localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int BUF_W   = LEN_CAP + PEND_W;
   localparam int CNT_W   = $clog2(LEN_CAP + BYTE_W);

   logic [ENT_W-1:0]   mem [NUM_SYMBOLS];
   logic [ENT_W-1:0]   rd_ff;
   logic [SYM_W-1:0]   idx;
   logic [LW-1:0]      len_sat;
   logic [LW-1:0]      rd_len;
   logic [LEN_CAP-1:0] rd_code;
   logic [LEN_CAP-1:0] code_left;
   logic [BUF_W-1:0]   merge_vec;
   logic [BUF_W-1:0]   buf_ff, buf_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  top_byte;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic               byte_valid_ff;
   logic [PAD_W-1:0]   padding_ff;
   logic               last_ff;

   assign idx = req_symbol[SYM_W-1:0];

   always_comb begin
      if (req_code_length > LENGTH_W'(LEN_CAP)) begin
         len_sat = LW'(LEN_CAP);
      end else begin
         len_sat = LW'(req_code_length);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_entry) begin
         mem[idx] <= {len_sat, req_code_value[LEN_CAP-1:0]};
      end
      if (cmd.rd_entry) begin
         rd_ff <= mem[idx];
      end
   end

   assign rd_len    = rd_ff[LEN_CAP +: LW];
   assign rd_code   = rd_ff[LEN_CAP-1:0];
   assign code_left = rd_code << (LW'(LEN_CAP) - rd_len);
   assign merge_vec = {code_left, PEND_W'(0)} >> count_ff[PAD_W-1:0];
   assign top_byte  = buf_ff[BUF_W-1 -: BYTE_W];

   always_comb begin
      buf_in   = buf_ff;
      count_in = count_ff;
      if (cmd.merge) begin
         buf_in   = buf_ff | merge_vec;
         count_in = count_ff + CNT_W'(rd_len);
      end
      if (cmd.emit) begin
         buf_in   = buf_ff << BYTE_W;
         count_in = count_ff - CNT_W'(BYTE_W);
      end
      if (cmd.flush) begin
         buf_in   = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         count_ff <= '0;
      end else begin
         buf_ff   <= buf_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_byte_ff   <= top_byte;
         byte_valid_ff <= 1'b1;
         padding_ff    <= '0;
         last_ff       <= 1'b0;
      end else if (cmd.flush) begin
         out_byte_ff   <= top_byte;
         byte_valid_ff <= (count_ff != '0);
         padding_ff    <= PAD_W'((PAD_W+1)'(BYTE_W) - {1'b0, count_ff[PAD_W-1:0]});
         last_ff       <= 1'b1;
      end
   end

   assign stat.count_ge8 = count_ff >= CNT_W'(BYTE_W);
   assign out_byte       = out_byte_ff;
   assign byte_valid     = byte_valid_ff;
   assign padding_bits   = padding_ff;
   assign last           = last_ff;

`ifndef SYNTHESIS
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (count_ff == '0 && buf_ff == '0))
      else $error("flush left bits pending");

   a_emit_drops_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (count_ff == $past(count_ff) - CNT_W'(BYTE_W)))
      else $error("emit did not drop one byte from the count");

   a_emit_needs_byte: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.count_ge8)
      else $error("emit without a full byte");
`endif

endmodule

// File: hw/rtl/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Huffman encoder back end: codebook load, symbol encode into a bit buffer,
// byte emission MSB first and end-of-chunk flush with padding count.
// ----------------------------------------------------------------------------
// Load: the next load can follow directly. Encode: the registered codebook
// read, a merge step, then n bytes out (0 to 4), one byte per cycle from the
// packing register while the response slot is free. Flush: result when free.
// Response stalls hold emission; the result register frees the request side.
// Reset clears the bit buffer, count and control; codebook entries are not
// cleared and are undefined until loaded.
module huffman_code_bit_packer #(
   parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
   parameter int NUM_SYMBOLS  = hcbp_pkg::DEF_NUM_SYMBOLS
) (
   input logic         clock,
   input logic         reset,
   hcbp_req_if.sink    req_bus,
   hcbp_rsp_if.source  rsp_bus
);
   import hcbp_pkg::*;

   hcbp_cmd_type  cmd;
   hcbp_stat_type stat;

   hcbp_ctrl #(
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_symbol (req_bus.symbol),
      .req_ready  (req_bus.ready),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .stat       (stat),
      .cmd        (cmd)
   );

   hcbp_dpath #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .NUM_SYMBOLS  (NUM_SYMBOLS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_symbol      (req_bus.symbol),
      .req_code_value  (req_bus.code_value),
      .req_code_length (req_bus.code_length),
      .cmd             (cmd),
      .stat            (stat),
      .out_byte        (rsp_bus.out_byte),
      .byte_valid      (rsp_bus.byte_valid),
      .padding_bits    (rsp_bus.padding_bits),
      .last            (rsp_bus.last)
   );

endmodule
